// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the blitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mbb_pkg.sv =====
`timescale 1ns / 1ps
package mbb_pkg;
    // Default geometry.
    localparam int SCREEN_WIDTH_DEF = 160;
    localparam int SCREEN_HEIGHT_DEF = 96;
    localparam int PHYS_SCALE_DEF = 1;
    localparam int MAX_PIC_DIM_DEF = 256;

    // Fixed field widths.
    localparam int CMD_W = 2;
    localparam int READ_X_W = 8;
    localparam int READ_Y_W = 7;
    localparam int PIX_W = 8;
    localparam int RGB_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W = 9;
    localparam int DIM_W = 9;
    localparam int SCALE_W = 3;
    localparam int ROP_W = 3;
    localparam int FLIP_W = 2;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Raster ops.
    localparam logic [ROP_W-1:0] ROP_COPY = 3'd0;
    localparam logic [ROP_W-1:0] ROP_AND = 3'd1;
    localparam logic [ROP_W-1:0] ROP_OR = 3'd2;
    localparam logic [ROP_W-1:0] ROP_KEEP = 3'd3;
    localparam logic [ROP_W-1:0] ROP_CLEAR = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIC_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIC_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIC_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_OP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_COLOR = 3'd7;
endpackage

// ===== rtl/mbb_ram.sv =====
`timescale 1ns / 1ps
module mbb_ram #(
    parameter int WIDTH = mbb_pkg::PIX_W,
    parameter int DEPTH = mbb_pkg::SCREEN_WIDTH_DEF * mbb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mbb_addr.sv =====
`timescale 1ns / 1ps
module mbb_addr #(
    parameter int PHYS_W = mbb_pkg::SCREEN_WIDTH_DEF * mbb_pkg::PHYS_SCALE_DEF,
    parameter int PHYS_H = mbb_pkg::SCREEN_HEIGHT_DEF * mbb_pkg::PHYS_SCALE_DEF,
    parameter int CW = 16,
    parameter int AW = $clog2(PHYS_W * PHYS_H)
) (
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_inside,
    output logic [AW-1:0]        o_addr
);
    localparam int XB = $clog2(PHYS_W);
    localparam int YB = $clog2(PHYS_H);

    // Clip against the physical screen, then form the row-major address.
    assign o_inside = (i_x >= 0) && (i_x < PHYS_W) && (i_y >= 0) && (i_y < PHYS_H);
    assign o_addr = AW'(i_y[YB-1:0]) * AW'(PHYS_W) + AW'(i_x[XB-1:0]);
endmodule

// ===== rtl/monochrome_bitmap_blitter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Word
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
// in        in         i_in_valid / o_in_ready      i_cmd, i_source_bit, i_read_x, i_read_y
// out       out        o_out_valid / i_out_ready    o_pixel_value, o_rgb_word, o_picture_done
//
// A start or no-op word goes straight to done; a read passes the read request and
// read data states. A source bit passes setup, then the coordinate, read and write
// states for each pixel of its scaled square (a clipped pixel skips the write), a
// read-modify-write through the frame store. After reset the frame store is cleared,
// one pixel a cycle, over all SCREEN_WIDTH * SCREEN_HEIGHT * PHYS_SCALE^2 pixels
// (15360 by default); no input word is taken meanwhile, configuration writes are. A
// stalled output holds its word while the next input word is already processed.
`include "assert_macros.svh"
module monochrome_bitmap_blitter #(
    parameter int SCREEN_WIDTH = mbb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mbb_pkg::SCREEN_HEIGHT_DEF,
    parameter int PHYS_SCALE = mbb_pkg::PHYS_SCALE_DEF,
    parameter int MAX_PIC_DIM = mbb_pkg::MAX_PIC_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mbb_pkg::CMD_W-1:0]       i_cmd,
    input  logic                            i_source_bit,
    input  logic [mbb_pkg::READ_X_W-1:0]    i_read_x,
    input  logic [mbb_pkg::READ_Y_W-1:0]    i_read_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mbb_pkg::PIX_W-1:0]       o_pixel_value,
    output logic [mbb_pkg::RGB_W-1:0]       o_rgb_word,
    output logic                            o_picture_done
);
    import mbb_pkg::*;

    localparam int PHYS_W = SCREEN_WIDTH * PHYS_SCALE;
    localparam int PHYS_H = SCREEN_HEIGHT * PHYS_SCALE;
    localparam int DEPTH = PHYS_W * PHYS_H;
    localparam int AW = $clog2(DEPTH);
    localparam int CUW = $clog2(MAX_PIC_DIM);
    localparam int DW = CUW + 1;
    localparam int SPW = DW + SCALE_W;
    localparam int CW_A = (DW + 5 > 13) ? DW + 5 : 13;
    localparam int CW_B = ($clog2(PHYS_W) + 2 > CW_A) ? $clog2(PHYS_W) + 2 : CW_A;
    localparam int CW = ($clog2(PHYS_H) + 2 > CW_B) ? $clog2(PHYS_H) + 2 : CW_B;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SETUP  = 9'b000000100,
        S_COORD  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_RDREQ  = 9'b001000000,
        S_RDDATA = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    function automatic logic [PIX_W-1:0] rop_apply(
        input logic [ROP_W-1:0] op,
        input logic [PIX_W-1:0] src,
        input logic [PIX_W-1:0] dst
    );
        logic [PIX_W-1:0] res;
        res = dst;
        case (op)
            ROP_COPY:  res = src;
            ROP_AND:   res = (src != '0) ? dst : '0;
            ROP_OR:    res = (src != '0) ? src : dst;
            ROP_KEEP:  res = dst;
            ROP_CLEAR: res = '0;
            default:   res = dst;
        endcase
        return res;
    endfunction

    t_state r_state, n_state;

    // Configuration registers.
    logic signed [COORD_W-1:0] r_origin_x, r_origin_y;
    logic [DIM_W-1:0]          r_pic_width, r_pic_height;
    logic [SCALE_W-1:0]        r_pic_scale;
    logic [ROP_W-1:0]          r_rop;
    logic [FLIP_W-1:0]         r_flip;
    logic [PIX_W-1:0]          r_paint;

    // Sequencer state.
    logic [AW-1:0]         r_clr;
    logic [CUW-1:0]        r_col, r_row;
    logic                  r_bit;
    logic [SPW-1:0]        r_bx, r_by, r_ext_w, r_ext_h;
    logic signed [CW-1:0]  r_ox, r_oy, r_x, r_y;
    logic [SCALE_W-1:0]    r_i, r_j, r_s;
    logic [AW-1:0]         r_addr;
    logic                  r_inside;
    logic [PIX_W-1:0]      r_res_pix;
    logic [RGB_W-1:0]      r_res_rgb;
    logic                  r_res_done;
    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_pix;
    logic [RGB_W-1:0]      r_out_rgb;
    logic                  r_out_done;

    logic [DW-1:0]         w_w, w_h, w_col_inc, w_row_inc;
    logic                  w_col_wrap, w_row_wrap;
    logic signed [CW-1:0]  w_xs, w_ys;
    logic                  w_inside;
    logic [AW-1:0]         w_addr;
    logic [PIX_W-1:0]      w_rdata, w_rd_val;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [PIX_W-1:0]      w_wdata;
    logic                  w_in_acc, w_out_free, w_step, w_last_i, w_last_j;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Picture size as used for the cursor: zero counts as one, large values saturate.
    always_comb begin
        if (r_pic_width == '0) begin
            w_w = DW'(1);
        end else if (int'(r_pic_width) > MAX_PIC_DIM) begin
            w_w = DW'(MAX_PIC_DIM);
        end else begin
            w_w = DW'(r_pic_width);
        end
        if (r_pic_height == '0) begin
            w_h = DW'(1);
        end else if (int'(r_pic_height) > MAX_PIC_DIM) begin
            w_h = DW'(MAX_PIC_DIM);
        end else begin
            w_h = DW'(r_pic_height);
        end
    end

    assign w_col_inc = DW'(r_col) + DW'(1);
    assign w_row_inc = DW'(r_row) + DW'(1);
    assign w_col_wrap = (w_col_inc >= w_w);
    assign w_row_wrap = (w_row_inc >= w_h);

    // Scaled offset of the current pixel, mirrored over the scaled picture size on each axis whose flip bit is set.
    always_comb begin
        w_xs = $signed(CW'(r_bx) + CW'(r_i));
        w_ys = $signed(CW'(r_by) + CW'(r_j));
        if (r_flip[0]) begin
            w_xs = $signed(CW'(r_ext_w)) - $signed(CW'(1)) - w_xs;
        end
        if (r_flip[1]) begin
            w_ys = $signed(CW'(r_ext_h)) - $signed(CW'(1)) - w_ys;
        end
    end

    mbb_addr #(
        .PHYS_W (PHYS_W),
        .PHYS_H (PHYS_H),
        .CW     (CW),
        .AW     (AW)
    ) u_addr (
        .i_x      (r_x),
        .i_y      (r_y),
        .o_inside (w_inside),
        .o_addr   (w_addr)
    );

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_addr;
        w_wdata = rop_apply(r_rop, r_bit ? r_paint : '0, w_rdata);
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_WRITE) begin
            w_we = 1'b1;
        end
    end

    mbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_last_i = (r_i == r_s - SCALE_W'(1));
    assign w_last_j = (r_j == r_s - SCALE_W'(1));
    assign w_step = ((r_state == S_READ) && !w_inside) || (r_state == S_WRITE);
    assign w_rd_val = r_inside ? w_rdata : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_cmd)
                        CMD_BIT:  n_state = S_SETUP;
                        CMD_READ: n_state = S_RDREQ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                n_state = (r_pic_scale == '0) ? S_DONE : S_COORD;
            end
            S_COORD: n_state = S_READ;
            S_READ, S_WRITE: begin
                if (r_state == S_READ && w_inside) begin
                    n_state = S_WRITE;
                end else if (w_last_i && w_last_j) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_COORD;
                end
            end
            S_RDREQ: n_state = S_RDDATA;
            S_RDDATA: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_col <= '0;
            r_row <= '0;
            r_out_valid <= 1'b0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_pic_width <= DIM_W'(1);
            r_pic_height <= DIM_W'(1);
            r_pic_scale <= SCALE_W'(1);
            r_rop <= ROP_COPY;
            r_flip <= '0;
            r_paint <= '1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ORIGIN_X:    r_origin_x <= $signed(i_cfg_data);
                    REG_ORIGIN_Y:    r_origin_y <= $signed(i_cfg_data);
                    REG_PIC_WIDTH:   r_pic_width <= i_cfg_data;
                    REG_PIC_HEIGHT:  r_pic_height <= i_cfg_data;
                    REG_PIC_SCALE:   r_pic_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_RASTER_OP:   r_rop <= i_cfg_data[ROP_W-1:0];
                    REG_FLIP_MODE:   r_flip <= i_cfg_data[FLIP_W-1:0];
                    REG_PAINT_COLOR: r_paint <= i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc && i_cmd == CMD_START) begin
                r_col <= '0;
                r_row <= '0;
            end
            if (r_state == S_SETUP) begin
                if (w_col_wrap) begin
                    r_col <= '0;
                    r_row <= w_row_wrap ? '0 : CUW'(w_row_inc);
                end else begin
                    r_col <= CUW'(w_col_inc);
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res_pix <= '0;
            r_res_rgb <= '0;
            r_res_done <= 1'b0;
            r_bit <= i_source_bit;
            r_x <= $signed(CW'(i_read_x));
            r_y <= $signed(CW'(i_read_y));
        end
        case (r_state)
            S_SETUP: begin
                r_bx <= SPW'(r_col) * SPW'(r_pic_scale);
                r_by <= SPW'(r_row) * SPW'(r_pic_scale);
                r_ext_w <= SPW'(w_w) * SPW'(r_pic_scale);
                r_ext_h <= SPW'(w_h) * SPW'(r_pic_scale);
                r_ox <= CW'(r_origin_x * PHYS_SCALE);
                r_oy <= CW'(r_origin_y * PHYS_SCALE);
                r_s <= r_pic_scale;
                r_i <= '0;
                r_j <= '0;
                r_res_done <= w_col_wrap && w_row_wrap;
            end
            S_COORD: begin
                r_x <= w_xs + r_ox;
                r_y <= w_ys + r_oy;
            end
            S_READ, S_RDREQ: begin
                r_addr <= w_addr;
                r_inside <= w_inside;
            end
            S_RDDATA: begin
                r_res_pix <= w_rd_val;
                r_res_rgb <= {w_rd_val, ~w_rd_val, ~w_rd_val, ~w_rd_val};
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_pix <= r_res_pix;
                    r_out_rgb <= r_res_rgb;
                    r_out_done <= r_res_done;
                end
            end
            default: ;
        endcase
        if (w_step) begin
            if (w_last_i) begin
                r_i <= '0;
                r_j <= r_j + SCALE_W'(1);
            end else begin
                r_i <= r_i + SCALE_W'(1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_rgb_word = r_out_rgb;
    assign o_picture_done = r_out_done;

    `ASSERT_IMPL(a_square_bounds, i_clk, i_rst_n, r_state == S_COORD, (r_i < r_s) && (r_j < r_s))
    `ASSERT_IMPL(a_write_clipped, i_clk, i_rst_n, w_we && (r_state != S_CLEAR), (r_state == S_WRITE) && r_inside)
    `ASSERT_NEXT(a_result_load, i_clk, i_rst_n, (r_state == S_DONE) && w_out_free, o_out_valid && (r_state == S_IDLE))
    `ASSERT_NEXT(a_cursor_wrap, i_clk, i_rst_n, (r_state == S_SETUP) && w_col_wrap && w_row_wrap, r_res_done && (r_col == '0) && (r_row == '0))
endmodule
